// ===== rtl/nmat_pkg.sv =====
// Shared types, constants and codes for the non-zero mean adaptive threshold block.
`timescale 1ns / 1ps
package nmat_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int COL_W       = 10;
  localparam int SLOT_W      = 4;
  localparam int STORE_DEPTH = (1 << SLOT_W) * MAX_WIDTH;
  localparam int DIM_W       = 11;
  localparam int SUM_W       = 16;
  localparam int CNT_W       = 8;
  localparam int QUO_W       = 8;
  localparam int DVS_W       = CNT_W + QUO_W - 1;
  localparam int DIV_CELLS   = QUO_W;

  typedef enum logic [2:0] {
    CFG_IMAGE_WIDTH   = 3'd0,
    CFG_IMAGE_HEIGHT  = 3'd1,
    CFG_WINDOW_WIDTH  = 3'd2,
    CFG_WINDOW_HEIGHT = 3'd3,
    CFG_OFFSET        = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DECIDE,
    S_CENTER,
    S_SCAN,
    S_DRAIN,
    S_DIVGO,
    S_DIVWAIT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       is_pad;
  } in_word_t;

  typedef struct packed {
    logic [7:0] mean_value;
    logic       is_marked;
    logic       last_of_frame;
  } out_word_t;

  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] rem;
    logic [DVS_W-1:0] dvs;
    logic [QUO_W-1:0] quo;
  } div_word_t;

endpackage

// ===== rtl/nmat_div_cell.sv =====
// One cell of the division chain: settles one quotient bit per cycle.
`timescale 1ns / 1ps
module nmat_div_cell
  import nmat_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  div_word_t cell_in,
  output div_word_t cell_out
);

  logic      ge;
  div_word_t word_r;
  div_word_t word_nxt;

  always_comb begin
    ge                = cell_in.rem >= SUM_W'(cell_in.dvs);
    word_nxt.valid    = cell_in.valid;
    word_nxt.rem      = ge ? cell_in.rem - SUM_W'(cell_in.dvs) : cell_in.rem;
    word_nxt.dvs      = cell_in.dvs >> 1;
    word_nxt.quo      = {cell_in.quo[QUO_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r.valid <= 1'b0;
    end else begin
      word_r.valid <= word_nxt.valid;
    end
    word_r.rem <= word_nxt.rem;
    word_r.dvs <= word_nxt.dvs;
    word_r.quo <= word_nxt.quo;
  end

  assign cell_out = word_r;

endmodule

// ===== rtl/nmat_div_chain.sv =====
// Row of division cells passing the partial remainder along each cycle.
`timescale 1ns / 1ps
module nmat_div_chain
  import nmat_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  div_word_t chain_in,
  output div_word_t chain_out
);

  div_word_t link [DIV_CELLS+1];

  assign link[0] = chain_in;

  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
    nmat_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_in  (link[i]),
      .cell_out (link[i+1])
    );
  end

  assign chain_out = link[DIV_CELLS];

endmodule

// ===== rtl/nonzero_mean_adaptive_threshold_top.sv =====
// Top level: line store, window scan, division chain and threshold output.
// A word that completes a window passes through the check, decide and centre states;
// then the scan reads one stored pixel per cycle over the window, a drain state and
// the eight-cell division chain follow before the result is offered.
// The next word is taken in the cycle after the result is taken; a word that completes
// nothing frees the input after the check and decide states. Synchronous reset (rst_n
// low) clears positions, frame flag and result valid; the line store is not cleared.
`timescale 1ns / 1ps
module nonzero_mean_adaptive_threshold_top
  import nmat_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_word_t         in_word,
  output logic             out_valid,
  input  logic             out_stall,
  output out_word_t        out_word,
  input  logic             cfg_wr_en,
  input  logic [2:0]       cfg_index,
  input  logic [DIM_W-1:0] cfg_data
);

  // Configuration registers.
  logic [DIM_W-1:0]  img_w_r, img_h_r;
  logic [3:0]        win_w_r, win_h_r;
  logic signed [8:0] offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r  <= DIM_W'(640);
      img_h_r  <= DIM_W'(480);
      win_w_r  <= 4'd11;
      win_h_r  <= 4'd11;
      offset_r <= 9'sd3;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH:   img_w_r  <= cfg_data;
        CFG_IMAGE_HEIGHT:  img_h_r  <= cfg_data;
        CFG_WINDOW_WIDTH:  win_w_r  <= cfg_data[3:0];
        CFG_WINDOW_HEIGHT: win_h_r  <= cfg_data[3:0];
        CFG_OFFSET:        offset_r <= $signed(cfg_data[8:0]);
        default: ;
      endcase
    end
  end

  // Half window size, held so that it never exceeds the image dimension.
  function automatic logic [2:0] half_of(input logic [3:0] size,
                                         input logic [DIM_W-1:0] dim);
    logic [2:0] h;
    h = (size == 4'd0) ? 3'd0 : 3'((size - 4'd1) >> 1);
    if (DIM_W'(h) > dim - DIM_W'(1)) begin
      h = 3'(dim - DIM_W'(1));
    end
    return h;
  endfunction

  logic [DIM_W-1:0] w_eff, h_eff;
  logic [2:0]       hw, hh;

  always_comb begin
    if (img_w_r == '0) begin
      w_eff = DIM_W'(1);
    end else if (img_w_r > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = img_w_r;
    end
    if (img_h_r == '0) begin
      h_eff = DIM_W'(1);
    end else if (img_h_r > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = img_h_r;
    end
    hw = half_of(win_w_r, w_eff);
    hh = half_of(win_h_r, h_eff);
  end

  // Control state.
  state_t state_r, state_nxt;
  logic   in_acc, out_acc;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;

  // Positions of the writing side and of the result side.
  logic [COL_W-1:0] in_col_r, in_row_r, out_col_r, out_row_r;
  logic             done_r;

  // Window bounds and the progress check.
  logic [COL_W-1:0] ys_r, ye_r, xs_r, xe_r, y_r, x_r;
  logic [21:0]      need_r, have_r;
  logic [DIM_W-1:0] row_sum, col_sum, row_hi, col_hi;
  logic [20:0]      need_prod, have_prod;

  always_comb begin
    row_sum   = DIM_W'(out_row_r) + DIM_W'(hh);
    col_sum   = DIM_W'(out_col_r) + DIM_W'(hw);
    row_hi    = (row_sum > h_eff - DIM_W'(1)) ? h_eff - DIM_W'(1) : row_sum;
    col_hi    = (col_sum > w_eff - DIM_W'(1)) ? w_eff - DIM_W'(1) : col_sum;
    need_prod = 21'(row_hi[COL_W-1:0]) * 21'(w_eff);
    have_prod = 21'(in_row_r) * 21'(w_eff);
  end

  // Line store: sixteen row slots of the widest row.
  logic [7:0]              line_mem [STORE_DEPTH];
  logic [7:0]              rd_data_r;
  logic [SLOT_W+COL_W-1:0] rd_addr;
  logic                    tag_ctr_r, tag_win_r;

  assign rd_addr = (state_r == S_CENTER) ? {out_row_r[SLOT_W-1:0], out_col_r}
                                         : {y_r[SLOT_W-1:0], x_r};

  always_ff @(posedge clk) begin
    if (in_acc && !in_word.is_pad) begin
      line_mem[{in_row_r[SLOT_W-1:0], in_col_r}] <= in_word.pixel;
    end
    rd_data_r <= line_mem[rd_addr];
  end

  // Division chain.
  logic [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0] cnt_r;
  logic [7:0]       ctr_pix_r;
  div_word_t        div_in, div_out;

  always_comb begin
    div_in.valid = (state_r == S_DIVGO);
    div_in.rem   = sum_r;
    div_in.dvs   = {cnt_r, (QUO_W-1)'(0)};
    div_in.quo   = '0;
  end

  nmat_div_chain u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .chain_in  (div_in),
    .chain_out (div_out)
  );

  // Threshold test on the finished mean.
  logic [7:0]         mean;
  logic signed [9:0]  diff, off_ext;
  logic               mark, last;
  out_word_t          out_word_r;

  always_comb begin
    mean    = (cnt_r == '0) ? 8'd0 : div_out.quo;
    diff    = $signed({2'b00, ctr_pix_r}) - $signed({2'b00, mean});
    off_ext = 10'(offset_r);
    if (offset_r > 9'sd0) begin
      mark = diff >= off_ext;
    end else if (offset_r < 9'sd0) begin
      mark = diff <= off_ext;
    end else begin
      mark = 1'b0;
    end
    last = (DIM_W'(out_col_r) + DIM_W'(1) >= w_eff)
        && (DIM_W'(out_row_r) + DIM_W'(1) >= h_eff);
  end

  assign out_word = out_word_r;

  // State register and next state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_valid) state_nxt = S_CHECK;
      S_CHECK:   state_nxt = S_DECIDE;
      S_DECIDE:  state_nxt = (done_r || have_r > need_r) ? S_CENTER : S_IDLE;
      S_CENTER:  state_nxt = S_SCAN;
      S_SCAN:    if (x_r == xe_r && y_r == ye_r) state_nxt = S_DRAIN;
      S_DRAIN:   state_nxt = S_DIVGO;
      S_DIVGO:   state_nxt = S_DIVWAIT;
      S_DIVWAIT: if (div_out.valid) state_nxt = S_OUT;
      S_OUT:     if (!out_stall) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Positions and frame flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      done_r    <= 1'b0;
      tag_ctr_r <= 1'b0;
      tag_win_r <= 1'b0;
    end else begin
      tag_ctr_r <= (state_r == S_CENTER);
      tag_win_r <= (state_r == S_SCAN);
      if (in_acc && !in_word.is_pad) begin
        if (DIM_W'(in_col_r) + DIM_W'(1) >= w_eff) begin
          in_col_r <= '0;
          if (DIM_W'(in_row_r) + DIM_W'(1) >= h_eff) begin
            in_row_r <= '0;
            done_r   <= 1'b1;
          end else begin
            in_row_r <= in_row_r + COL_W'(1);
          end
        end else begin
          in_col_r <= in_col_r + COL_W'(1);
        end
      end
      if (out_acc) begin
        if (DIM_W'(out_col_r) + DIM_W'(1) >= w_eff) begin
          out_col_r <= '0;
          if (DIM_W'(out_row_r) + DIM_W'(1) >= h_eff) begin
            out_row_r <= '0;
            done_r    <= 1'b0;
          end else begin
            out_row_r <= out_row_r + COL_W'(1);
          end
        end else begin
          out_col_r <= out_col_r + COL_W'(1);
        end
      end
    end
  end

  // Window scan, accumulation and result register.
  always_ff @(posedge clk) begin
    if (state_r == S_CHECK) begin
      need_r <= 22'(need_prod) + 22'(col_hi[COL_W-1:0]);
      have_r <= 22'(have_prod) + 22'(in_col_r);
      ys_r   <= (out_row_r > COL_W'(hh)) ? out_row_r - COL_W'(hh) : '0;
      ye_r   <= row_hi[COL_W-1:0];
      xs_r   <= (out_col_r > COL_W'(hw)) ? out_col_r - COL_W'(hw) : '0;
      xe_r   <= col_hi[COL_W-1:0];
    end
    if (state_r == S_DECIDE) begin
      sum_r <= '0;
      cnt_r <= '0;
    end
    if (state_r == S_CENTER) begin
      x_r <= xs_r;
      y_r <= ys_r;
    end
    if (state_r == S_SCAN) begin
      if (x_r == xe_r) begin
        x_r <= xs_r;
        y_r <= y_r + COL_W'(1);
      end else begin
        x_r <= x_r + COL_W'(1);
      end
    end
    if (tag_ctr_r) begin
      ctr_pix_r <= rd_data_r;
    end
    if (tag_win_r && rd_data_r != 8'd0) begin
      sum_r <= sum_r + SUM_W'(rd_data_r);
      cnt_r <= cnt_r + CNT_W'(1);
    end
    if (state_r == S_DIVWAIT && div_out.valid) begin
      out_word_r.mean_value    <= mean;
      out_word_r.is_marked     <= mark;
      out_word_r.last_of_frame <= last;
    end
  end

endmodule
